// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by pom_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define POM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define POM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pom_pkg.sv =====
package pom_pkg;

   // default geometry
   localparam int TREE_DEPTH_DEF    = 4;
   localparam int BUCKET_SLOTS_DEF  = 4;
   localparam int DATA_W_DEF        = 64;
   localparam int STASH_ENTRIES_DEF = 32;

   // fixed field widths
   localparam int ID_W       = 7;
   localparam int LEAF_MAX_W = 12;

   // stash operations
   localparam logic [2:0] STASH_NOP       = 3'd0;
   localparam logic [2:0] STASH_SCAN      = 3'd1;
   localparam logic [2:0] STASH_FETCH_PUT = 3'd2;
   localparam logic [2:0] STASH_ACC_READ  = 3'd3;
   localparam logic [2:0] STASH_ACC_WRITE = 3'd4;
   localparam logic [2:0] STASH_CAND      = 3'd5;
   localparam logic [2:0] STASH_PICK      = 3'd6;

   typedef struct packed {
      logic [2:0]            op;
      logic [ID_W-1:0]       id;
      logic [LEAF_MAX_W-1:0] leaf;
      logic [LEAF_MAX_W-1:0] mask;
   } stash_cmd_type;

   typedef struct packed {
      logic            hit;
      logic            full;
      logic            cand_any;
      logic [ID_W-1:0] pick_id;
   } stash_sts_type;

endpackage

// ===== rtl/core/pom_ram.sv =====
module pom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pom_stash.sv =====
module pom_stash #(
   parameter int TREE_DEPTH    = pom_pkg::TREE_DEPTH_DEF,
   parameter int DATA_W        = pom_pkg::DATA_W_DEF,
   parameter int STASH_ENTRIES = pom_pkg::STASH_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pom_pkg::stash_cmd_type cmd,
   input  logic [DATA_W-1:0]     wr_data,
   output pom_pkg::stash_sts_type sts,
   output logic [DATA_W-1:0]     rd_data
);

   localparam int SIX_W  = $clog2(STASH_ENTRIES);
   localparam int LEAF_W = TREE_DEPTH;

   logic [STASH_ENTRIES-1:0] valid_ff, match_ff, cand_ff;
   logic [STASH_ENTRIES-1:0] match_in, cand_in;
   logic [pom_pkg::ID_W-1:0] ids_ff [STASH_ENTRIES];
   logic [LEAF_W-1:0]        leaf_ff [STASH_ENTRIES];
   logic [pom_pkg::ID_W-1:0] pick_id_ff;
   logic [SIX_W-1:0]         free_idx, hit_idx, cand_idx;
   logic                     free_any, hit, cand_any;
   logic                     ram_we, ram_re;
   logic [SIX_W-1:0]         ram_waddr, ram_raddr;
   logic                     do_insert;

   function automatic logic [SIX_W-1:0] lowest(input logic [STASH_ENTRIES-1:0] v);
      logic [SIX_W-1:0] r;
      r = '0;
      for (int i = STASH_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = SIX_W'(i);
         end
      end
      return r;
   endfunction

   // per-entry compares
   always_comb begin
      for (int k = 0; k < STASH_ENTRIES; k++) begin
         match_in[k] = valid_ff[k] && (ids_ff[k] == cmd.id);
         cand_in[k]  = valid_ff[k] &&
            (((leaf_ff[k] ^ cmd.leaf[LEAF_W-1:0]) & cmd.mask[LEAF_W-1:0]) == '0);
      end
   end

   assign free_idx = lowest(~valid_ff);
   assign free_any = ~(&valid_ff);
   assign hit_idx  = lowest(match_ff);
   assign hit      = |match_ff;
   assign cand_idx = lowest(cand_ff);
   assign cand_any = |cand_ff;

   // insert into lowest free entry when the id is not held yet
   assign do_insert = ((cmd.op == pom_pkg::STASH_FETCH_PUT) ||
                       (cmd.op == pom_pkg::STASH_ACC_WRITE)) && !hit && free_any;

   // data memory port control
   always_comb begin
      ram_we    = do_insert || ((cmd.op == pom_pkg::STASH_ACC_WRITE) && hit);
      ram_waddr = hit ? hit_idx : free_idx;
      ram_re    = (cmd.op == pom_pkg::STASH_ACC_READ) ||
                  ((cmd.op == pom_pkg::STASH_PICK) && cand_any);
      ram_raddr = (cmd.op == pom_pkg::STASH_PICK) ? cand_idx : hit_idx;
   end

   // valid, match and candidate vectors
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         match_ff <= '0;
         cand_ff  <= '0;
      end else begin
         unique case (cmd.op) inside
            pom_pkg::STASH_SCAN: begin
               match_ff <= match_in;
            end
            pom_pkg::STASH_CAND: begin
               cand_ff <= cand_in;
            end
            pom_pkg::STASH_PICK: begin
               if (cand_any) begin
                  cand_ff[cand_idx]  <= 1'b0;
                  valid_ff[cand_idx] <= 1'b0;
               end
            end
            pom_pkg::STASH_FETCH_PUT, pom_pkg::STASH_ACC_WRITE: begin
               if (do_insert) begin
                  valid_ff[free_idx] <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // entry tags
   always_ff @(posedge clock) begin
      if (do_insert) begin
         ids_ff[free_idx]  <= cmd.id;
         leaf_ff[free_idx] <= cmd.leaf[LEAF_W-1:0];
      end else if (((cmd.op == pom_pkg::STASH_ACC_READ) ||
                    (cmd.op == pom_pkg::STASH_ACC_WRITE)) && hit) begin
         leaf_ff[hit_idx] <= cmd.leaf[LEAF_W-1:0];
      end
      if ((cmd.op == pom_pkg::STASH_PICK) && cand_any) begin
         pick_id_ff <= ids_ff[cand_idx];
      end
   end

   pom_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STASH_ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   assign sts.hit      = hit;
   assign sts.full     = !free_any;
   assign sts.cand_any = cand_any;
   assign sts.pick_id  = pick_id_ff;

endmodule

// ===== rtl/core/path_oram_controller.sv =====
// an access reads the old leaf, fetches each slot on its path into the stash, finds the
// block (a read that hits then reads its data), and writes the path back leaf to root
// an id out of range is answered in the cycle after it is taken
// one access at a time; the next can be taken in the cycle after the result beat
// rsp_valid pulses for one cycle at the end of each access; the receiver cannot stall
// after reset a clearing pass over every tree slot (124 at defaults) keeps busy high
module path_oram_controller #(
   parameter int TREE_DEPTH    = pom_pkg::TREE_DEPTH_DEF,
   parameter int BUCKET_SLOTS  = pom_pkg::BUCKET_SLOTS_DEF,
   parameter int DATA_W        = pom_pkg::DATA_W_DEF,
   parameter int STASH_ENTRIES = pom_pkg::STASH_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [6:0]  req_block_id,
   input  logic [63:0] req_write_data,
   input  logic [3:0]  req_new_leaf,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_data,
   output logic        rsp_found,
   output logic        rsp_stash_overflow
);

   localparam int NUM_SLOTS = ((2 << TREE_DEPTH) - 1) * BUCKET_SLOTS;
   localparam int NUM_IDS   = (NUM_SLOTS < 128) ? NUM_SLOTS : 128;
   localparam int SLOT_AW   = $clog2(NUM_SLOTS);
   localparam int ID_AW     = $clog2(NUM_IDS);
   localparam int CLR_W     = $clog2(NUM_SLOTS + 1);
   localparam int LEAF_W    = TREE_DEPTH;
   localparam int LVL_W     = $clog2(TREE_DEPTH + 1);
   localparam int BKT_W     = TREE_DEPTH + 1;
   localparam int ZC_W      = $clog2(BUCKET_SLOTS + 1);
   localparam int TW        = 1 + pom_pkg::ID_W + DATA_W;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LMAP   = 4'd2;
   localparam logic [3:0] ST_FRD    = 4'd3;
   localparam logic [3:0] ST_FCHK   = 4'd4;
   localparam logic [3:0] ST_FPUT   = 4'd5;
   localparam logic [3:0] ST_FIND   = 4'd6;
   localparam logic [3:0] ST_ACC    = 4'd7;
   localparam logic [3:0] ST_RDAT   = 4'd8;
   localparam logic [3:0] ST_WBSET  = 4'd9;
   localparam logic [3:0] ST_WBPICK = 4'd10;
   localparam logic [3:0] ST_RESP   = 4'd11;

   logic [3:0]               state_ff, state_in;
   logic [CLR_W-1:0]         clr_ff, clr_in;
   logic [LVL_W-1:0]         lvl_ff, lvl_in;
   logic [ZC_W-1:0]          z_ff, z_in;
   logic                     wpend_ff, wpend_in;
   logic [SLOT_AW-1:0]       waddr_ff, waddr_in;
   logic [LEAF_W-1:0]        old_ff, old_in, nleaf_ff, nleaf_in;
   logic [pom_pkg::ID_W-1:0] id_ff, id_in, fid_ff, fid_in;
   logic                     mode_ff, mode_in;
   logic [DATA_W-1:0]        wdata_ff, wdata_in, fdata_ff, fdata_in, rdata_ff, rdata_in;
   logic                     found_ff, found_in, ovf_ff, ovf_in;

   logic [BKT_W-1:0]         bucket;
   logic [SLOT_AW-1:0]       slot_addr;
   logic [LEAF_W-1:0]        prefix_mask;
   logic                     accept, last_slot_in_bucket;

   logic                     tree_we, tree_re;
   logic [SLOT_AW-1:0]       tree_waddr;
   logic [TW-1:0]            tree_wdata, tree_rd;
   logic                     leaf_we, leaf_re;
   logic [ID_AW-1:0]         leaf_waddr, leaf_raddr;
   logic [LEAF_W-1:0]        leaf_wdata, leaf_rd;

   pom_pkg::stash_cmd_type   stash_cmd;
   pom_pkg::stash_sts_type   stash_sts;
   logic [DATA_W-1:0]        stash_wdata, stash_rd;

   logic                     rd_real;
   logic [pom_pkg::ID_W-1:0] rd_id;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // bucket on the old path at the current level, then slot address
   assign bucket    = ((BKT_W'(1) << lvl_ff) - BKT_W'(1)) +
                      BKT_W'(old_ff >> (LVL_W'(TREE_DEPTH) - lvl_ff));
   assign slot_addr = SLOT_AW'(32'(bucket) * BUCKET_SLOTS) + SLOT_AW'(z_ff);
   assign prefix_mask = {LEAF_W{1'b1}} << (LVL_W'(TREE_DEPTH) - lvl_ff);
   assign last_slot_in_bucket = (z_ff == ZC_W'(BUCKET_SLOTS - 1));

   assign rd_real = tree_rd[TW-1];
   assign rd_id   = tree_rd[TW-2 -: pom_pkg::ID_W];

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      lvl_in   = lvl_ff;
      z_in     = z_ff;
      wpend_in = 1'b0;
      waddr_in = waddr_ff;
      old_in   = old_ff;
      nleaf_in = nleaf_ff;
      id_in    = id_ff;
      fid_in   = fid_ff;
      mode_in  = mode_ff;
      wdata_in = wdata_ff;
      fdata_in = fdata_ff;
      rdata_in = rdata_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;

      tree_we    = 1'b0;
      tree_waddr = slot_addr;
      tree_wdata = '0;
      tree_re    = 1'b0;
      leaf_we    = 1'b0;
      leaf_waddr = id_ff[ID_AW-1:0];
      leaf_wdata = nleaf_ff;
      leaf_re    = 1'b0;
      leaf_raddr = rd_id[ID_AW-1:0];

      stash_cmd      = '0;
      stash_cmd.op   = pom_pkg::STASH_NOP;
      stash_cmd.id   = fid_ff;
      stash_cmd.leaf = pom_pkg::LEAF_MAX_W'(leaf_rd);
      stash_cmd.mask = '0;
      stash_wdata    = fdata_ff;

      // write-back beat from the previous pick
      if (wpend_ff) begin
         tree_we    = 1'b1;
         tree_waddr = waddr_ff;
         tree_wdata = {1'b1, stash_sts.pick_id, stash_rd};
      end

      unique case (state_ff)
         ST_CLEAR: begin
            tree_we    = 1'b1;
            tree_waddr = clr_ff[SLOT_AW-1:0];
            tree_wdata = '0;
            leaf_we    = (clr_ff < CLR_W'(NUM_IDS));
            leaf_waddr = clr_ff[ID_AW-1:0];
            leaf_wdata = '0;
            clr_in     = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               id_in    = req_block_id;
               wdata_in = DATA_W'(req_write_data);
               nleaf_in = LEAF_W'(req_new_leaf);
               rdata_in = '0;
               found_in = 1'b0;
               ovf_in   = 1'b0;
               if ({1'b0, req_block_id} >= 8'(NUM_IDS)) begin
                  state_in = ST_RESP;
               end else begin
                  leaf_re    = 1'b1;
                  leaf_raddr = req_block_id[ID_AW-1:0];
                  state_in   = ST_LMAP;
               end
            end
         end
         ST_LMAP: begin
            old_in   = leaf_rd;
            leaf_we  = 1'b1;
            lvl_in   = '0;
            z_in     = '0;
            state_in = ST_FRD;
         end
         ST_FRD: begin
            tree_re  = 1'b1;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (rd_real) begin
               stash_cmd.op = pom_pkg::STASH_SCAN;
               stash_cmd.id = rd_id;
               leaf_re      = 1'b1;
               tree_we      = 1'b1;
               tree_wdata   = '0;
               fid_in       = rd_id;
               fdata_in     = tree_rd[DATA_W-1:0];
               state_in     = ST_FPUT;
            end else begin
               // empty slot, move on
               if (last_slot_in_bucket) begin
                  z_in = '0;
                  if (lvl_ff == LVL_W'(TREE_DEPTH)) begin
                     state_in = ST_FIND;
                  end else begin
                     lvl_in   = lvl_ff + LVL_W'(1);
                     state_in = ST_FRD;
                  end
               end else begin
                  z_in     = z_ff + ZC_W'(1);
                  state_in = ST_FRD;
               end
            end
         end
         ST_FPUT: begin
            stash_cmd.op = pom_pkg::STASH_FETCH_PUT;
            if (!stash_sts.hit && stash_sts.full) begin
               ovf_in = 1'b1;
            end
            if (last_slot_in_bucket) begin
               z_in = '0;
               if (lvl_ff == LVL_W'(TREE_DEPTH)) begin
                  state_in = ST_FIND;
               end else begin
                  lvl_in   = lvl_ff + LVL_W'(1);
                  state_in = ST_FRD;
               end
            end else begin
               z_in     = z_ff + ZC_W'(1);
               state_in = ST_FRD;
            end
         end
         ST_FIND: begin
            stash_cmd.op = pom_pkg::STASH_SCAN;
            stash_cmd.id = id_ff;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            stash_cmd.id   = id_ff;
            stash_cmd.leaf = pom_pkg::LEAF_MAX_W'(nleaf_ff);
            stash_wdata    = wdata_ff;
            lvl_in         = LVL_W'(TREE_DEPTH);
            state_in       = ST_WBSET;
            if (!mode_ff) begin
               if (stash_sts.hit) begin
                  stash_cmd.op = pom_pkg::STASH_ACC_READ;
                  found_in     = 1'b1;
                  state_in     = ST_RDAT;
               end
            end else begin
               stash_cmd.op = pom_pkg::STASH_ACC_WRITE;
               if (stash_sts.hit || !stash_sts.full) begin
                  found_in = 1'b1;
                  rdata_in = wdata_ff;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_RDAT: begin
            rdata_in = stash_rd;
            state_in = ST_WBSET;
         end
         ST_WBSET: begin
            stash_cmd.op   = pom_pkg::STASH_CAND;
            stash_cmd.leaf = pom_pkg::LEAF_MAX_W'(old_ff);
            stash_cmd.mask = pom_pkg::LEAF_MAX_W'(prefix_mask);
            z_in           = '0;
            state_in       = ST_WBPICK;
         end
         ST_WBPICK: begin
            if ((z_ff != ZC_W'(BUCKET_SLOTS)) && stash_sts.cand_any) begin
               stash_cmd.op = pom_pkg::STASH_PICK;
               wpend_in     = 1'b1;
               waddr_in     = slot_addr;
               z_in         = z_ff + ZC_W'(1);
            end else if (lvl_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               lvl_in   = lvl_ff - LVL_W'(1);
               state_in = ST_WBSET;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         wpend_ff <= wpend_in;
      end
   end

   // payload and counters
   always_ff @(posedge clock) begin
      lvl_ff   <= lvl_in;
      z_ff     <= z_in;
      waddr_ff <= waddr_in;
      old_ff   <= old_in;
      nleaf_ff <= nleaf_in;
      id_ff    <= id_in;
      fid_ff   <= fid_in;
      mode_ff  <= mode_in;
      wdata_ff <= wdata_in;
      fdata_ff <= fdata_in;
      rdata_ff <= rdata_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
   end

   pom_ram #(
      .WIDTH (TW),
      .DEPTH (NUM_SLOTS)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_en   (tree_re),
      .rd_addr (slot_addr),
      .rd_data (tree_rd)
   );

   pom_ram #(
      .WIDTH (LEAF_W),
      .DEPTH (NUM_IDS)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_waddr),
      .wr_data (leaf_wdata),
      .rd_en   (leaf_re),
      .rd_addr (leaf_raddr),
      .rd_data (leaf_rd)
   );

   pom_stash #(
      .TREE_DEPTH    (TREE_DEPTH),
      .DATA_W        (DATA_W),
      .STASH_ENTRIES (STASH_ENTRIES)
   ) u_stash (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stash_cmd),
      .wr_data (stash_wdata),
      .sts     (stash_sts),
      .rd_data (stash_rd)
   );

   // result beat
   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_read_data      = 64'(rdata_ff);
   assign rsp_found          = found_ff;
   assign rsp_stash_overflow = ovf_ff;

endmodule

// ===== rtl/core/pom_checker.sv =====
`include "assert_macros.svh"

module pom_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic [63:0] rsp_read_data
);

   // an accepted request keeps the block busy in the next cycle
   `POM_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accept")

   // a result beat lasts one cycle
   `POM_ASSERT_NEXT(a_single_beat, rsp_valid, !rsp_valid, "result beat held")

   // the block is ready again right after a result beat
   `POM_ASSERT_NEXT(a_ready_after_beat, rsp_valid, !busy, "still busy after result")

   // absent blocks read as zero
   `POM_ASSERT_IMPL(a_absent_zero, rsp_valid && !rsp_found, rsp_read_data == 64'd0,
                    "nonzero data without found")

endmodule

bind path_oram_controller pom_checker u_checker (.*);
